// ----- hw/rtl/touch_gesture_detector_assert.svh -----
// Assertion macros for the touch gesture detector.
// TGD_ASSERT_IMPLY checks a same-cycle implication and TGD_ASSERT_NEXT
// checks a next-cycle implication. Both are held off while rst_n is low.
`ifndef TOUCH_GESTURE_DETECTOR_ASSERT_SVH
`define TOUCH_GESTURE_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define TGD_ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("tgd assertion failed");
`define TGD_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("tgd assertion failed");
`else
`define TGD_ASSERT_IMPLY(lbl, clk, rst_n, a, c)
`define TGD_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

// ----- hw/rtl/tgd_pkg.sv -----
`default_nettype none
package tgd_pkg;

    typedef enum logic [2:0] {
        REG_PRESS_DELAY   = 3'd0,
        REG_TAP_MIN       = 3'd1,
        REG_TAP_MAX       = 3'd2,
        REG_TAP_MAX_OFFS  = 3'd3,
        REG_QUIT_LEFT     = 3'd4,
        REG_QUIT_BOTTOM   = 3'd5,
        REG_QUIT_RIGHT    = 3'd6,
        REG_QUIT_TOP      = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic        [15:0] press_delay_ms;
        logic        [15:0] tap_min_ms;
        logic        [15:0] tap_max_ms;
        logic        [15:0] tap_max_offset;
        logic signed [15:0] quit_left;
        logic signed [15:0] quit_bottom;
        logic signed [15:0] quit_right;
        logic signed [15:0] quit_top;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        press_delay_ms: 16'd50,
        tap_min_ms:     16'd30,
        tap_max_ms:     16'd150,
        tap_max_offset: 16'd3277,
        quit_left:      16'sd24576,
        quit_bottom:    16'sd24576,
        quit_right:     16'sd32767,
        quit_top:       16'sd32767
    };

    typedef struct packed {
        logic        [30:0] now_ms;
        logic               touch_down;
        logic        [30:0] sample_ms;
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_y;
    } frame_t;

    typedef struct packed {
        logic               is_pressing;
        logic               is_dragging;
        logic               press_event;
        logic               release_event;
        logic               double_tap;
        logic               drag_gesture;
        logic               quit_hit;
        logic               tap_time_ok;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic        [15:0] lim;
        logic signed [15:0] last_x;
        logic signed [15:0] last_y;
    } track_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tgd_track.sv -----
`default_nettype none
`include "touch_gesture_detector_assert.svh"
module tgd_track #(
    parameter int unsigned DOUBLE_TAP_WINDOW_MS = 200
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tgd_pkg::cfg_t   cfg,
    input  wire tgd_pkg::frame_t frame,
    input  wire logic            step,
    output tgd_pkg::track_t      res
);

    localparam logic signed [31:0] WIN = 32'(DOUBLE_TAP_WINDOW_MS);

    logic               pressing_reg, pressing_next;
    logic               dragging_reg, dragging_next;
    logic        [30:0] begin_time_reg, begin_time_next;
    logic signed [15:0] begin_x_reg, begin_x_next;
    logic signed [15:0] begin_y_reg, begin_y_next;
    logic        [30:0] finish_time_reg, finish_time_next;
    logic signed [15:0] finish_x_reg, finish_x_next;
    logic signed [15:0] finish_y_reg, finish_y_next;
    logic               slot_reg, slot_next;
    logic        [30:0] tap_starts_reg [2];
    logic        [30:0] tap_starts_next [2];
    logic        [30:0] tap_ends_reg [2];
    logic        [30:0] tap_ends_next [2];

    logic               press_ev, release_ev, dbl, quit;
    logic signed [31:0] end_gap, tap_span, dur;
    logic        [31:0] drag_lim, rel_lim;
    logic               in_box;

    assign end_gap  = signed'({1'b0, frame.sample_ms}) - signed'({1'b0, tap_ends_reg[0]});
    assign tap_span = signed'({1'b0, finish_time_reg})
                    - signed'({1'b0, tap_starts_reg[slot_reg]});
    assign drag_lim = {1'b0, begin_time_reg} + {16'd0, cfg.press_delay_ms};
    assign rel_lim  = {1'b0, finish_time_reg} + {16'd0, cfg.press_delay_ms};
    assign in_box   = (finish_x_reg >= cfg.quit_left) && (finish_x_reg <= cfg.quit_right)
                   && (finish_y_reg >= cfg.quit_bottom) && (finish_y_reg <= cfg.quit_top);

    always_comb
    begin
        pressing_next    = pressing_reg;
        dragging_next    = dragging_reg;
        begin_time_next  = begin_time_reg;
        begin_x_next     = begin_x_reg;
        begin_y_next     = begin_y_reg;
        finish_time_next = finish_time_reg;
        finish_x_next    = finish_x_reg;
        finish_y_next    = finish_y_reg;
        slot_next        = slot_reg;
        tap_starts_next  = tap_starts_reg;
        tap_ends_next    = tap_ends_reg;
        press_ev         = 1'b0;
        release_ev       = 1'b0;
        dbl              = 1'b0;
        quit             = 1'b0;
        if (frame.touch_down)
        begin
            finish_time_next = frame.sample_ms;
            finish_x_next    = frame.sample_x;
            finish_y_next    = frame.sample_y;
            if (!pressing_reg)
            begin
                pressing_next   = 1'b1;
                press_ev        = 1'b1;
                dragging_next   = 1'b0;
                begin_time_next = frame.sample_ms;
                begin_x_next    = frame.sample_x;
                begin_y_next    = frame.sample_y;
                if (slot_reg && (end_gap > WIN))
                begin
                    slot_next = 1'b0;
                end
                tap_starts_next[slot_next] = frame.sample_ms;
            end
            else if ({1'b0, frame.sample_ms} > drag_lim)
            begin
                dragging_next = 1'b1;
            end
        end
        else if (pressing_reg && (rel_lim < {1'b0, frame.now_ms}))
        begin
            pressing_next           = 1'b0;
            release_ev              = 1'b1;
            dragging_next           = 1'b0;
            tap_ends_next[slot_reg] = finish_time_reg;
            slot_next               = 1'b0;
            if (tap_span < WIN)
            begin
                if (!slot_reg)
                begin
                    slot_next = 1'b1;
                end
                else
                begin
                    dbl  = 1'b1;
                    quit = in_box;
                end
            end
        end
    end

    assign dur = signed'({1'b0, finish_time_next}) - signed'({1'b0, begin_time_next});

    always_comb
    begin
        res.is_pressing   = pressing_next;
        res.is_dragging   = dragging_next;
        res.press_event   = press_ev;
        res.release_event = release_ev;
        res.double_tap    = dbl;
        res.drag_gesture  = dur > signed'({16'd0, cfg.tap_max_ms});
        res.quit_hit      = quit;
        res.tap_time_ok   = release_ev && (dur > signed'({16'd0, cfg.tap_min_ms}))
                                       && (dur < signed'({16'd0, cfg.tap_max_ms}));
        res.dx            = {finish_x_next[15], finish_x_next} - {begin_x_next[15], begin_x_next};
        res.dy            = {finish_y_next[15], finish_y_next} - {begin_y_next[15], begin_y_next};
        res.lim           = cfg.tap_max_offset;
        res.last_x        = finish_x_next;
        res.last_y        = finish_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressing_reg    <= 1'b0;
            dragging_reg    <= 1'b0;
            begin_time_reg  <= '0;
            begin_x_reg     <= '0;
            begin_y_reg     <= '0;
            finish_time_reg <= '0;
            finish_x_reg    <= '0;
            finish_y_reg    <= '0;
            slot_reg        <= 1'b0;
            tap_starts_reg  <= '{default: '0};
            tap_ends_reg    <= '{default: '0};
        end
        else if (step)
        begin
            pressing_reg    <= pressing_next;
            dragging_reg    <= dragging_next;
            begin_time_reg  <= begin_time_next;
            begin_x_reg     <= begin_x_next;
            begin_y_reg     <= begin_y_next;
            finish_time_reg <= finish_time_next;
            finish_x_reg    <= finish_x_next;
            finish_y_reg    <= finish_y_next;
            slot_reg        <= slot_next;
            tap_starts_reg  <= tap_starts_next;
            tap_ends_reg    <= tap_ends_next;
        end
    end

    `TGD_ASSERT_IMPLY(a_drag_needs_press, clk, rst_n, dragging_reg, pressing_reg)
    `TGD_ASSERT_NEXT(a_press_holds, clk, rst_n, step && res.press_event, pressing_reg)
    `TGD_ASSERT_IMPLY(a_dbl_from_slot1, clk, rst_n, step && res.double_tap, slot_reg)
    `TGD_ASSERT_NEXT(a_dbl_clears_slot, clk, rst_n, step && res.double_tap, !slot_reg)
    `TGD_ASSERT_IMPLY(a_quit_needs_dbl, clk, rst_n, res.quit_hit, res.double_tap)

endmodule
`default_nettype wire

// ----- hw/rtl/touch_gesture_detector.sv -----
// Touch gesture detector: one word in per touch frame, one word out.
// Input stream s_*: s_tdata holds now_ms, sample_ms, sample_x, sample_y,
// s_tuser holds touch_down. Output stream m_*: m_tdata holds the eight
// gesture flags followed by last_x and last_y.
// Config channel cfg_*: cfg_index selects one of eight 16-bit registers,
// always ready; write only while the stream is idle.
// A word taken into the input register has its result loaded into the
// output register when that register is empty or its word moves on, and
// leaves the block from there.
// Throughput: one word per cycle unless m_tready stalls; the tracking state
// updates as a word moves from the input register to the output register.
// A stalled m_tready holds the output word; the input register still takes
// one more word before s_tready drops, so up to two words can be in flight.
// Reset (rst_n low, asynchronous) empties both registers, clears the press
// and tap-history state and loads the register defaults.
`default_nettype none
module touch_gesture_detector #(
    parameter int unsigned DOUBLE_TAP_WINDOW_MS = 200
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [30:0] now_ms, [61:31] sample_ms, [77:62] sample_x, [93:78] sample_y, pad
    input  wire logic [95:0] s_tdata,
    // [0] touch_down
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] is_pressing, [1] is_dragging, [2] press_event, [3] release_event,
    // [4] single_tap, [5] double_tap, [6] drag_gesture, [7] quit_hit,
    // [23:8] last_x, [39:24] last_y
    output logic [39:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    tgd_pkg::cfg_t    cfg_reg;
    tgd_pkg::frame_t  frame_reg;
    tgd_pkg::track_t  track;
    logic [39:0]      out_reg;
    logic             v0_reg, v1_reg;
    logic             en0, en1;
    logic signed [33:0] dx_sq, dy_sq;
    logic        [31:0] lim_sq;
    logic        [32:0] dist_sq;
    logic             single;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= tgd_pkg::CFG_RESET;
        end
        else if (cfg_valid)
        begin
            case (tgd_pkg::cfg_idx_t'(cfg_index))
                tgd_pkg::REG_PRESS_DELAY:  cfg_reg.press_delay_ms <= cfg_data;
                tgd_pkg::REG_TAP_MIN:      cfg_reg.tap_min_ms     <= cfg_data;
                tgd_pkg::REG_TAP_MAX:      cfg_reg.tap_max_ms     <= cfg_data;
                tgd_pkg::REG_TAP_MAX_OFFS: cfg_reg.tap_max_offset <= cfg_data;
                tgd_pkg::REG_QUIT_LEFT:    cfg_reg.quit_left      <= signed'(cfg_data);
                tgd_pkg::REG_QUIT_BOTTOM:  cfg_reg.quit_bottom    <= signed'(cfg_data);
                tgd_pkg::REG_QUIT_RIGHT:   cfg_reg.quit_right     <= signed'(cfg_data);
                tgd_pkg::REG_QUIT_TOP:     cfg_reg.quit_top       <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when its word moves on
    assign en1      = !v1_reg || m_tready;
    assign en0      = !v0_reg || en1;
    assign s_tready = en0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                v0_reg <= s_tvalid;
            end
            if (en1)
            begin
                v1_reg <= v0_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0 && s_tvalid)
        begin
            frame_reg.now_ms     <= s_tdata[30:0];
            frame_reg.touch_down <= s_tuser[0];
            frame_reg.sample_ms  <= s_tdata[61:31];
            frame_reg.sample_x   <= signed'(s_tdata[77:62]);
            frame_reg.sample_y   <= signed'(s_tdata[93:78]);
        end
    end

    tgd_track #(
        .DOUBLE_TAP_WINDOW_MS (DOUBLE_TAP_WINDOW_MS)
    ) u_track (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .frame (frame_reg),
        .step  (v0_reg && en1),
        .res   (track)
    );

    assign dx_sq   = track.dx * track.dx;
    assign dy_sq   = track.dy * track.dy;
    assign lim_sq  = {16'd0, track.lim} * {16'd0, track.lim};
    assign dist_sq = {1'b0, dx_sq[31:0]} + {1'b0, dy_sq[31:0]};
    assign single  = track.tap_time_ok && (dist_sq < {1'b0, lim_sq});

    always_ff @(posedge clk)
    begin
        if (en1 && v0_reg)
        begin
            out_reg <= {track.last_y, track.last_x, track.quit_hit, track.drag_gesture,
                        track.double_tap, single, track.release_event,
                        track.press_event, track.is_dragging, track.is_pressing};
        end
    end

    assign m_tvalid = v1_reg;
    assign m_tdata  = out_reg;

endmodule
`default_nettype wire

// ----- tb/sv/tb_touch_gesture_detector.sv -----
module tb_touch_gesture_detector;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DTAP_WINDOW_MS = 200;
    localparam int STALL_LIMIT    = 4000;
    localparam int LONG_HOLD      = 300;

    // one result word, lowest bit last
    typedef struct packed {
        logic signed [15:0] last_y;
        logic signed [15:0] last_x;
        logic               quit_hit;
        logic               drag_gesture;
        logic               double_tap;
        logic               single_tap;
        logic               release_event;
        logic               press_event;
        logic               is_dragging;
        logic               is_pressing;
    } gesture_t;

    class gesture_scoreboard;
        tgd_pkg::cfg_t      regs;
        bit                 pressing;
        bit                 dragging;
        bit                 slot;
        logic [30:0]        begin_ms;
        logic [30:0]        finish_ms;
        logic signed [15:0] begin_x;
        logic signed [15:0] begin_y;
        logic signed [15:0] finish_x;
        logic signed [15:0] finish_y;
        logic [30:0]        tap_start_ms [2];
        logic [30:0]        tap_end_ms [2];
        gesture_t           pending_gestures [$];
        int                 errors;
        int                 words_seen;

        function new();
            regs = tgd_pkg::CFG_RESET;
            pressing = 1'b0;
            dragging = 1'b0;
            slot = 1'b0;
            begin_ms = '0;
            finish_ms = '0;
            begin_x = '0;
            begin_y = '0;
            finish_x = '0;
            finish_y = '0;
            tap_start_ms[0] = '0;
            tap_start_ms[1] = '0;
            tap_end_ms[0] = '0;
            tap_end_ms[1] = '0;
            errors = 0;
            words_seen = 0;
        endfunction

        function void set_reg(tgd_pkg::cfg_idx_t idx, logic [15:0] value);
            case (idx)
                tgd_pkg::REG_PRESS_DELAY:  regs.press_delay_ms = value;
                tgd_pkg::REG_TAP_MIN:      regs.tap_min_ms = value;
                tgd_pkg::REG_TAP_MAX:      regs.tap_max_ms = value;
                tgd_pkg::REG_TAP_MAX_OFFS: regs.tap_max_offset = value;
                tgd_pkg::REG_QUIT_LEFT:    regs.quit_left = value;
                tgd_pkg::REG_QUIT_BOTTOM:  regs.quit_bottom = value;
                tgd_pkg::REG_QUIT_RIGHT:   regs.quit_right = value;
                tgd_pkg::REG_QUIT_TOP:     regs.quit_top = value;
                default:          ;
            endcase
        endfunction

        function gesture_t track_gesture(tgd_pkg::frame_t f);
            gesture_t r;
            bit       s;
            longint   dur;
            longint   dx;
            longint   dy;
            longint   lim;
            r = '0;
            s = slot;
            if (f.touch_down) begin
                finish_ms = f.sample_ms;
                finish_x = f.sample_x;
                finish_y = f.sample_y;
                if (!pressing) begin
                    pressing = 1'b1;
                    r.press_event = 1'b1;
                    dragging = 1'b0;
                    begin_ms = finish_ms;
                    begin_x = finish_x;
                    begin_y = finish_y;
                    if (s && longint'(begin_ms) - longint'(tap_end_ms[0]) > DTAP_WINDOW_MS)
                        s = 1'b0;
                    tap_start_ms[s] = begin_ms;
                end
                else if (longint'(finish_ms) >
                         longint'(begin_ms) + longint'(regs.press_delay_ms)) begin
                    dragging = 1'b1;
                end
            end
            else if (pressing && longint'(finish_ms) <
                     longint'(f.now_ms) - longint'(regs.press_delay_ms)) begin
                pressing = 1'b0;
                r.release_event = 1'b1;
                dragging = 1'b0;
                tap_end_ms[s] = finish_ms;
                if (longint'(finish_ms) - longint'(tap_start_ms[s]) < DTAP_WINDOW_MS) begin
                    if (s) begin
                        r.double_tap = 1'b1;
                        r.quit_hit = finish_x >= $signed(regs.quit_left) &&
                                     finish_x <= $signed(regs.quit_right) &&
                                     finish_y >= $signed(regs.quit_bottom) &&
                                     finish_y <= $signed(regs.quit_top);
                    end
                    s = !s;
                end
                else begin
                    s = 1'b0;
                end
            end
            slot = s;
            dur = longint'(finish_ms) - longint'(begin_ms);
            if (r.release_event) begin
                dx = longint'(finish_x) - longint'(begin_x);
                dy = longint'(finish_y) - longint'(begin_y);
                lim = longint'(regs.tap_max_offset);
                r.single_tap = dx * dx + dy * dy < lim * lim &&
                               dur > longint'(regs.tap_min_ms) &&
                               dur < longint'(regs.tap_max_ms);
            end
            r.drag_gesture = dur > 0 && dur > longint'(regs.tap_max_ms);
            r.is_pressing = pressing;
            r.is_dragging = dragging;
            r.last_x = finish_x;
            r.last_y = finish_y;
            return r;
        endfunction

        function void note_frame(tgd_pkg::frame_t f);
            pending_gestures.push_back(track_gesture(f));
        endfunction

        task report(string msg);
            errors++;
            $display("%0t mismatch: %s", $time, msg);
        endtask

        task compare(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("word %0d %s got %h want %h", words_seen, field, got, want));
        endtask

        task check_word(logic [39:0] word);
            gesture_t got;
            gesture_t want;
            got = word;
            if (pending_gestures.size() == 0) begin
                report($sformatf("word %0d arrived with nothing outstanding", words_seen));
            end
            else begin
                want = pending_gestures.pop_front();
                compare("is_pressing", 16'(got.is_pressing), 16'(want.is_pressing));
                compare("is_dragging", 16'(got.is_dragging), 16'(want.is_dragging));
                compare("press_event", 16'(got.press_event), 16'(want.press_event));
                compare("release_event", 16'(got.release_event), 16'(want.release_event));
                compare("single_tap", 16'(got.single_tap), 16'(want.single_tap));
                compare("double_tap", 16'(got.double_tap), 16'(want.double_tap));
                compare("drag_gesture", 16'(got.drag_gesture), 16'(want.drag_gesture));
                compare("quit_hit", 16'(got.quit_hit), 16'(want.quit_hit));
                compare("last_x", got.last_x, want.last_x);
                compare("last_y", got.last_y, want.last_y);
            end
            words_seen++;
        endtask
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [30:0] now_ms, [61:31] sample_ms, [77:62] sample_x, [93:78] sample_y, pad
    logic [95:0] s_tdata = '0;
    // [0] touch_down
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [0] is_pressing, [1] is_dragging, [2] press_event, [3] release_event,
    // [4] single_tap, [5] double_tap, [6] drag_gesture, [7] quit_hit,
    // [23:8] last_x, [39:24] last_y
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    gesture_scoreboard sb;
    bit                src_burst = 1'b0;
    bit                snk_burst = 1'b0;
    bit                hold_req = 1'b0;
    longint            clock_ms = 0;
    int                items_sent = 0;
    int                quiet_cycles = 0;

    touch_gesture_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [15:0] q15(int v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic int rnd_q15();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int jitter(int spread);
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    task automatic put(longint now, bit down, longint smp, int x, int y);
        tgd_pkg::frame_t f;
        int              gap;
        f.now_ms = now[30:0];
        f.touch_down = down;
        f.sample_ms = smp[30:0];
        f.sample_x = q15(x);
        f.sample_y = q15(y);
        gap = src_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= {2'b00, f.sample_y, f.sample_x, f.sample_ms, f.now_ms};
        s_tuser <= f.touch_down;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_frame(f);
        items_sent++;
    endtask

    task automatic write_reg(tgd_pkg::cfg_idx_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic load_regs(logic [15:0] pd, logic [15:0] tmin, logic [15:0] tmax,
                             logic [15:0] offs, logic [15:0] lft, logic [15:0] bot,
                             logic [15:0] rgt, logic [15:0] top);
        write_reg(tgd_pkg::REG_PRESS_DELAY, pd);
        write_reg(tgd_pkg::REG_TAP_MIN, tmin);
        write_reg(tgd_pkg::REG_TAP_MAX, tmax);
        write_reg(tgd_pkg::REG_TAP_MAX_OFFS, offs);
        write_reg(tgd_pkg::REG_QUIT_LEFT, lft);
        write_reg(tgd_pkg::REG_QUIT_BOTTOM, bot);
        write_reg(tgd_pkg::REG_QUIT_RIGHT, rgt);
        write_reg(tgd_pkg::REG_QUIT_TOP, top);
        cfg_valid <= 1'b0;
    endtask

    // block must be empty before a register write
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending_gestures.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // press, optional early release, accepted release
    task automatic gesture();
        int     n;
        int     hold;
        int     x0;
        int     y0;
        int     spread;
        int     lft;
        int     rgt;
        int     bot;
        int     top;
        longint st;
        longint fin;
        longint rel;
        longint pd;
        pd = sb.regs.press_delay_ms;
        case ($urandom_range(0, 3))
            0: hold = $urandom_range(0, 60);
            1: hold = $urandom_range(sb.regs.tap_min_ms, sb.regs.tap_max_ms);
            2: hold = sb.regs.tap_max_ms + $urandom_range(0, 200);
            default: hold = $urandom_range(0, 250);
        endcase
        lft = $signed(sb.regs.quit_left);
        rgt = $signed(sb.regs.quit_right);
        bot = $signed(sb.regs.quit_bottom);
        top = $signed(sb.regs.quit_top);
        if ($urandom_range(0, 2) == 0 && rgt >= lft && top >= bot)
        begin
            x0 = lft + int'($urandom_range(0, rgt - lft));
            y0 = bot + int'($urandom_range(0, top - bot));
        end
        else
        begin
            x0 = rnd_q15();
            y0 = rnd_q15();
        end
        case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = sb.regs.tap_max_offset / 2;
            2: spread = sb.regs.tap_max_offset;
            default: spread = 65535;
        endcase
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
        begin
            st = clock_ms + (n > 1 ? longint'(hold) * i / (n - 1) : 0);
            put(st + $urandom_range(0, 8), 1'b1, st, x0 + jitter(spread), y0 + jitter(spread));
        end
        fin = clock_ms + (n > 1 ? hold : 0);
        if ($urandom_range(0, 3) == 0)
            put(fin + $urandom_range(0, pd), 1'b0, $urandom, rnd_q15(), rnd_q15());
        rel = fin + pd + 1 + $urandom_range(0, 30);
        put(rel, 1'b0, $urandom, rnd_q15(), rnd_q15());
        clock_ms = rel + $urandom_range(0, 260);
        if (clock_ms > 64'h7FF0_0000)
            clock_ms = $urandom_range(0, 1000);
    endtask

    task automatic random_phase(int count);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            if ($urandom_range(0, 7) == 0)
                src_burst = !src_burst;
            case ($urandom_range(0, 9))
                0: put($urandom, 1'($urandom_range(0, 1)), $urandom, rnd_q15(), rnd_q15());
                1: put(clock_ms + $urandom_range(0, 300), 1'($urandom_range(0, 1)),
                       clock_ms - $urandom_range(0, 500), rnd_q15(), rnd_q15());
                default: gesture();
            endcase
        end
    endtask

    // result side
    initial
    begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                hold_req = 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = snk_burst ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            if ($urandom_range(0, 15) == 0)
                snk_burst = !snk_burst;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_touch_gesture_detector: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int lo_x;
        int lo_y;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        clock_ms = $urandom_range(0, 1 << 29);

        // directed words at reset settings
        put(0, 1'b0, 0, 0, 0);
        put(31'h7FFF_FFFF, 1'b1, 31'h7FFF_FFFF, -32768, 32767);
        put(0, 1'b0, 0, 0, 0);
        put(31'h7FFF_FFFF, 1'b0, 31'h7FFF_FFFF, 32767, -32768);
        put(5, 1'b1, 0, 32767, -32768);
        put(100, 1'b0, 0, 0, 0);
        // double tap ending in the quit box
        put(1000, 1'b1, 1000, 30000, 30000);
        put(1080, 1'b1, 1080, 30100, 29900);
        put(1100, 1'b0, 1100, 0, 0);
        put(1200, 1'b0, 1200, 0, 0);
        put(1250, 1'b1, 1250, 30050, 30050);
        put(1300, 1'b1, 1300, 30000, 30000);
        put(1400, 1'b0, 1400, 0, 0);
        // double tap outside the box
        put(2000, 1'b1, 2000, -32768, -32768);
        put(2100, 1'b0, 31'h7FFF_FFFF, -1, -1);
        put(2150, 1'b1, 2150, -32768, -32768);
        put(2180, 1'b1, 2180, -32768, -32767);
        put(2300, 1'b0, 0, 32767, 32767);
        // long drag with a large move
        put(3000, 1'b1, 3000, 0, 0);
        put(3100, 1'b1, 3100, -32768, 32767);
        put(3300, 1'b1, 3300, 32767, -32768);
        put(3400, 1'b0, 3400, 0, 0);

        hold_req = 1'b1;
        random_phase(180);

        settle();
        load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        random_phase(150);

        // inverted quit box
        settle();
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        random_phase(100);

        settle();
        load_regs(tgd_pkg::CFG_RESET.press_delay_ms, tgd_pkg::CFG_RESET.tap_min_ms,
                  tgd_pkg::CFG_RESET.tap_max_ms, tgd_pkg::CFG_RESET.tap_max_offset,
                  tgd_pkg::CFG_RESET.quit_left, tgd_pkg::CFG_RESET.quit_bottom,
                  tgd_pkg::CFG_RESET.quit_right, tgd_pkg::CFG_RESET.quit_top);
        random_phase(150);

        for (int k = 0; k < 3; k++)
        begin
            settle();
            lo_x = rnd_q15();
            lo_y = rnd_q15();
            load_regs(16'($urandom_range(0, 100)), 16'($urandom_range(0, 60)),
                      16'($urandom_range(60, 300)), 16'($urandom_range(0, 12000)),
                      q15(lo_x), q15(lo_y),
                      q15(lo_x + int'($urandom_range(0, 20000))),
                      q15(lo_y + int'($urandom_range(0, 20000))));
            if (k == 1)
                hold_req = 1'b1;
            random_phase(180);
        end

        settle();
        if (sb.errors == 0)
            $display("tb_touch_gesture_detector: PASS");
        else
            $display("tb_touch_gesture_detector: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/tgd_pkg.sv
hw/rtl/tgd_track.sv
hw/rtl/touch_gesture_detector.sv
tb/sv/tb_touch_gesture_detector.sv
